// ===== rtl/cds_pkg.sv =====
// cds_pkg: types, constants and small functions for the calendar date stepper
// used by cds_in_stage, cds_date_core and calendar_date_stepper
// no dependencies
package cds_pkg;

    localparam logic        CMD_LOAD    = 1'b0;
    localparam logic        CMD_ADVANCE = 1'b1;

    localparam logic [4:0]  MAX_STEP    = 5'd31;
    localparam logic [11:0] YEAR_MIN    = 12'd1900;
    localparam logic [11:0] YEAR_MAX    = 12'd4095;

    localparam logic [4:0]  RST_DAY     = 5'd1;
    localparam logic [3:0]  RST_MONTH   = 4'd1;
    localparam logic [11:0] RST_YEAR    = 12'd1900;
    localparam logic [2:0]  RST_WEEKDAY = 3'd1;
    localparam logic [8:0]  RST_Y400    = 9'd300;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic        command;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [11:0] load_year;
        logic [4:0]  step_days;
        logic [5:0]  q100_year;
        logic [11:0] year_adj;
        logic [5:0]  q100_adj;
    } t_in_word;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [2:0]  weekday;
        t_status     status;
    } t_result;

    // floor(y / 100) for any 12-bit y, by reciprocal multiply
    function automatic logic [5:0] div100(input logic [11:0] y);
        logic [22:0] prod;
        prod = {11'd0, y} * 23'd1311;
        return prod[22:17];
    endfunction

    // value mod 7 by folding octal digits (8 is 1 mod 7)
    function automatic logic [2:0] mod7(input logic [12:0] v);
        logic [4:0] a;
        logic [3:0] b;
        logic [2:0] c;
        a = {2'd0, v[2:0]} + {2'd0, v[5:3]} + {2'd0, v[8:6]} + {2'd0, v[11:9]}
            + {4'd0, v[12]};
        b = {1'b0, a[2:0]} + {2'd0, a[4:3]};
        c = b[2:0] + {2'd0, b[3]};
        return (c == 3'd7) ? 3'd0 : c;
    endfunction

    // month length, zero for a month outside 1 to 12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:       len = 5'd31;
            default:                  len = 5'd0;
        endcase
        return len;
    endfunction

    // per-month weekday offset, January first
    function automatic logic [2:0] month_offset(input logic [3:0] m);
        logic [2:0] off;
        case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== rtl/calendar_date_stepper.sv =====
// calendar_date_stepper: gregorian date and weekday keeper with load and advance
// instantiates cds_in_stage and cds_date_core; depends on cds_pkg
//
// usage
//   input channel (i_in_valid / o_in_ready) carries one command word: a load of
//   day, month and year, or an advance of the stored date by 0 to 31 days
//   output channel (o_out_valid / i_out_ready) returns one word per command:
//   the stored date, its weekday (0 sunday) and a status
//   (ok, load rejected as invalid date, advance refused past year 4095)
//   path: the input register holds each accepted command, then the result register holds its result word
//   throughput: one command per cycle while the receiver takes each result word; the stored date is read and rewritten
//   by one pass of date logic between the input register and the result register
//   when the receiver stalls, the result register holds its word and the input
//   register takes one more command, after which o_in_ready drops until the
//   result word is taken
//   reset: both registers empty, stored date 1 january 1900, a monday
module calendar_date_stepper
    import cds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [11:0] i_load_year,
    input  logic [4:0]  i_step_days,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_day,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic [2:0]  o_weekday,
    output logic [1:0]  o_status
);

    logic     s1_valid;
    t_in_word s1_word;
    logic     take;
    t_result  result;

    logic     r_out_valid;
    t_result  r_out;

    assign take = s1_valid && (!r_out_valid || i_out_ready);

    cds_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .i_command    (i_command),
        .i_load_day   (i_load_day),
        .i_load_month (i_load_month),
        .i_load_year  (i_load_year),
        .i_step_days  (i_step_days),
        .i_take       (take),
        .o_ready      (o_in_ready),
        .o_valid      (s1_valid),
        .o_word       (s1_word)
    );

    cds_date_core u_date_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (take),
        .i_word   (s1_word),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_day       = r_out.day;
    assign o_month     = r_out.month;
    assign o_year      = r_out.year;
    assign o_weekday   = r_out.weekday;
    assign o_status    = r_out.status;

endmodule

// ===== rtl/cds_in_stage.sv =====
// cds_in_stage: input register of the date stepper, with the century quotients
// of the load year worked out ahead of the date logic
// depends on cds_pkg
module cds_in_stage
    import cds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_command,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [11:0] i_load_year,
    input  logic [4:0]  i_step_days,
    input  logic        i_take,
    output logic        o_ready,
    output logic        o_valid,
    output t_in_word    o_word
);

    logic        r_valid;
    t_in_word    r_word;
    t_in_word    n_word;
    logic [11:0] year_adj;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // january and february count with the previous year
    assign year_adj = i_load_year - {11'd0, (i_load_month < 4'd3)};

    always_comb begin
        n_word.command    = i_command;
        n_word.load_day   = i_load_day;
        n_word.load_month = i_load_month;
        n_word.load_year  = i_load_year;
        n_word.step_days  = i_step_days;
        n_word.q100_year  = div100(i_load_year);
        n_word.year_adj   = year_adj;
        n_word.q100_adj   = div100(year_adj);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= n_word;
        end
    end

endmodule

// ===== rtl/cds_date_core.sv =====
// cds_date_core: stored date and weekday, load check and the two-stage month carry
// holds the date state; depends on cds_pkg
module cds_date_core
    import cds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_update,
    input  t_in_word i_word,
    output t_result  o_result
);

    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [11:0] r_year;
    logic [2:0]  r_weekday;
    logic [8:0]  r_y400;

    logic [4:0]  n_day;
    logic [3:0]  n_month;
    logic [11:0] n_year;
    logic [2:0]  n_weekday;
    logic [8:0]  n_y400;
    t_status     status;

    // load side
    logic [3:0]  l_q400;
    logic [11:0] l_rem100;
    logic [11:0] l_rem400;
    logic [8:0]  l_y400;
    logic        l_leap;
    logic [4:0]  l_len;
    logic        l_ok;
    logic [12:0] l_sum;
    logic [2:0]  l_weekday;

    // advance side
    logic [4:0]  a_step;
    logic        a_leap;
    logic [5:0]  a_d0;
    logic [4:0]  a_len1;
    logic [5:0]  a_d1;
    logic [3:0]  a_m1;
    logic        a_wrap1;
    logic [4:0]  a_len2;
    logic [5:0]  a_d2;
    logic [3:0]  a_m2;
    logic        a_wrap2;
    logic        a_ovf;
    logic [5:0]  a_wd_sum;
    logic [2:0]  a_weekday;
    logic [8:0]  a_y400_inc;

    assign l_q400   = i_word.q100_year[5:2];
    assign l_rem100 = i_word.load_year - ({6'd0, i_word.q100_year} * 12'd100);
    assign l_rem400 = i_word.load_year - ({8'd0, l_q400} * 12'd400);
    assign l_y400   = l_rem400[8:0];
    assign l_leap   = (l_y400[1:0] == 2'd0) && ((l_rem100[6:0] != 7'd0) || (l_y400 == 9'd0));
    assign l_len    = month_len(i_word.load_month, l_leap);
    assign l_ok     = (l_len != 5'd0) && (i_word.load_day != 5'd0)
                      && (i_word.load_day <= l_len) && (i_word.load_year >= YEAR_MIN);

    assign l_sum = {1'b0, i_word.year_adj}
                 + {3'd0, i_word.year_adj[11:2]}
                 - {7'd0, i_word.q100_adj}
                 + {9'd0, i_word.q100_adj[5:2]}
                 + {10'd0, month_offset(i_word.load_month)}
                 + {8'd0, i_word.load_day};
    assign l_weekday = mod7(l_sum);

    assign a_step = (i_word.step_days > MAX_STEP) ? MAX_STEP : i_word.step_days;
    assign a_leap = (r_y400[1:0] == 2'd0) && (r_y400 != 9'd100) && (r_y400 != 9'd200)
                    && (r_y400 != 9'd300);
    assign a_d0   = {1'b0, r_day} + {1'b0, a_step};
    assign a_len1 = month_len(r_month, a_leap);
    assign a_len2 = month_len(a_m1, a_leap);

    always_comb begin
        a_d1    = a_d0;
        a_m1    = r_month;
        a_wrap1 = 1'b0;
        if (a_d0 > {1'b0, a_len1}) begin
            a_d1 = a_d0 - {1'b0, a_len1};
            if (r_month == 4'd12) begin
                a_m1    = 4'd1;
                a_wrap1 = 1'b1;
            end else begin
                a_m1 = r_month + 4'd1;
            end
        end
    end

    always_comb begin
        a_d2    = a_d1;
        a_m2    = a_m1;
        a_wrap2 = 1'b0;
        if (a_d1 > {1'b0, a_len2}) begin
            a_d2 = a_d1 - {1'b0, a_len2};
            if (a_m1 == 4'd12) begin
                a_m2    = 4'd1;
                a_wrap2 = 1'b1;
            end else begin
                a_m2 = a_m1 + 4'd1;
            end
        end
    end

    assign a_ovf      = (a_wrap1 || a_wrap2) && (r_year == YEAR_MAX);
    assign a_wd_sum   = {3'd0, r_weekday} + {1'b0, a_step};
    assign a_weekday  = mod7({7'd0, a_wd_sum});
    assign a_y400_inc = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;

    always_comb begin
        n_day     = r_day;
        n_month   = r_month;
        n_year    = r_year;
        n_weekday = r_weekday;
        n_y400    = r_y400;
        status    = ST_OK;
        if (i_word.command == CMD_LOAD) begin
            if (l_ok) begin
                n_day     = i_word.load_day;
                n_month   = i_word.load_month;
                n_year    = i_word.load_year;
                n_weekday = l_weekday;
                n_y400    = l_y400;
            end else begin
                status = ST_BAD_DATE;
            end
        end else begin
            if (a_ovf) begin
                status = ST_OVERFLOW;
            end else begin
                n_day     = a_d2[4:0];
                n_month   = a_m2;
                n_weekday = a_weekday;
                if (a_wrap1 || a_wrap2) begin
                    n_year = r_year + 12'd1;
                    n_y400 = a_y400_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day     <= RST_DAY;
            r_month   <= RST_MONTH;
            r_year    <= RST_YEAR;
            r_weekday <= RST_WEEKDAY;
            r_y400    <= RST_Y400;
        end else if (i_update) begin
            r_day     <= n_day;
            r_month   <= n_month;
            r_year    <= n_year;
            r_weekday <= n_weekday;
            r_y400    <= n_y400;
        end
    end

    always_comb begin
        o_result.day     = n_day;
        o_result.month   = n_month;
        o_result.year    = n_year;
        o_result.weekday = n_weekday;
        o_result.status  = status;
    end

endmodule
